/* rtl/core/corr_pkg.sv */
package corr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_CHECK,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_VX1,
    OP_VX2,
    OP_VY1,
    OP_VY2,
    OP_N1,
    OP_N2,
    OP_RHS,
    OP_PROD,
    OP_C2,
    OP_LHS
  } op_t;

  typedef enum logic [1:0] {
    PH_XX,
    PH_YY,
    PH_XY
  } acc_phase_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_UNDEF = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;

  // Magnitude bits of the Q1.14 result and the scale of the squared ratio.
  localparam int Q_BITS     = 15;
  localparam int FRAC_SHIFT = 28;

endpackage

/* rtl/core/corr_mul.sv */
module corr_mul #(
  parameter int LW = 169,
  parameter int MB = 69
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [LW-1:0] a,
  input  logic [MB-1:0] b,
  output logic          done,
  output logic [LW-1:0] product
);

  localparam int CW = (MB > 1) ? $clog2(MB) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [LW-1:0] acc;
  logic [LW-1:0] ash;
  logic [MB-1:0] bsh;

  // Shift-add: one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        ash  <= a;
        bsh  <= b;
      end else if (busy) begin
        if (bsh[0]) begin
          acc <= acc + ash;
        end
        ash <= ash << 1;
        bsh <= bsh >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

/* rtl/core/corr_acc.sv */
module corr_acc #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_SAMPLES = 65536,
  parameter int CNT_W       = 17,
  parameter int SW          = 34,
  parameter int QW          = 50
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] x,
  input  logic [SAMPLE_BITS-1:0] y,
  output logic                   done,
  output logic [CNT_W-1:0]       count,
  output logic                   overflowed,
  output logic [SW-1:0]          sx,
  output logic [SW-1:0]          sy,
  output logic [QW-1:0]          sxx,
  output logic [QW-1:0]          syy,
  output logic [QW-1:0]          sxy
);

  localparam int PB = 2 * SAMPLE_BITS;

  logic                   busy;
  logic                   take;
  corr_pkg::acc_phase_t   phase;
  logic [SAMPLE_BITS-1:0] xr;
  logic [SAMPLE_BITS-1:0] yr;
  logic [SAMPLE_BITS-1:0] ma;
  logic [SAMPLE_BITS-1:0] mb;
  logic signed [PB-1:0]   p;
  logic [QW-1:0]          p_ext;

  // One signed multiplier serves the three products of a pair in turn.
  always_comb begin
    case (phase)
      corr_pkg::PH_XX: begin ma = xr; mb = xr; end
      corr_pkg::PH_YY: begin ma = yr; mb = yr; end
      corr_pkg::PH_XY: begin ma = xr; mb = yr; end
      default:         begin ma = xr; mb = yr; end
    endcase
  end

  assign p     = $signed(ma) * $signed(mb);
  assign p_ext = {{(QW - PB){p[PB-1]}}, p};
  assign done  = busy && (phase == corr_pkg::PH_XY);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy       <= 1'b0;
      take       <= 1'b0;
      phase      <= corr_pkg::PH_XX;
      count      <= '0;
      overflowed <= 1'b0;
      sx         <= '0;
      sy         <= '0;
      sxx        <= '0;
      syy        <= '0;
      sxy        <= '0;
    end else if (start) begin
      xr    <= x;
      yr    <= y;
      busy  <= 1'b1;
      phase <= corr_pkg::PH_XX;
      take  <= (count < CNT_W'(MAX_SAMPLES));
      if (!(count < CNT_W'(MAX_SAMPLES))) begin
        overflowed <= 1'b1;
      end
    end else if (busy) begin
      case (phase)
        corr_pkg::PH_XX: begin
          if (take) begin
            sx  <= sx + {{(SW - SAMPLE_BITS){xr[SAMPLE_BITS-1]}}, xr};
            sy  <= sy + {{(SW - SAMPLE_BITS){yr[SAMPLE_BITS-1]}}, yr};
            sxx <= sxx + p_ext;
          end
          phase <= corr_pkg::PH_YY;
        end
        corr_pkg::PH_YY: begin
          if (take) begin
            syy <= syy + p_ext;
          end
          phase <= corr_pkg::PH_XY;
        end
        default: begin
          if (take) begin
            sxy   <= sxy + p_ext;
            count <= count + 1'b1;
          end
          busy  <= 1'b0;
          phase <= corr_pkg::PH_XX;
        end
      endcase
    end
  end

endmodule

/* rtl/core/streaming_correlation_core.sv */
// Channel | Direction | Signals
// input   | in        | in_valid, in_ready, x_sample, y_sample, last_sample
// output  | out       | out_valid, out_ready, correlation, status
//
// A pair is accepted, then its three products go through one multiplier.
// A last pair adds the finish: up to 38 multiplies on one shift-add unit of PW
// bits (PW = 2*SAMPLE_BITS + 2*clog2(MAX_SAMPLES+1) + 3).
// Reset is synchronous and clears all sums and the result valid flag.
// A finished result is held in the output register; the next request is taken
// meanwhile, and a later result waits until that register is free.
module streaming_correlation_core #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  input  logic                   last_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            correlation,
  output logic [1:0]             status
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SW    = SAMPLE_BITS + CNT_W + 1;
  localparam int QW    = 2 * SAMPLE_BITS + CNT_W + 1;
  localparam int PW    = QW + CNT_W + 2;
  localparam int LW    = 2 * PW + 31;
  localparam int QB    = corr_pkg::Q_BITS;
  localparam int BW    = $clog2(QB);

  corr_pkg::state_t state, state_next;
  corr_pkg::op_t    op, op_next;

  logic             last_r;
  logic             acc_start;
  logic             acc_clear;
  logic             acc_done;
  logic [CNT_W-1:0] count;
  logic             overflowed;
  logic [SW-1:0]    sx, sy;
  logic [QW-1:0]    sxx, syy, sxy;

  logic             mul_start;
  logic             mul_done;
  logic [LW-1:0]    mul_a;
  logic [PW-1:0]    mul_b;
  logic [LW-1:0]    p;

  logic [LW-1:0]    vx, vy, num, rhs, prod, c2;
  logic [QB-1:0]    q;
  logic [BW-1:0]    bitn;
  logic [QB-1:0]    cand;

  logic [LW-1:0]    n_ext, sx_ext, sy_ext, sxx_ext, syy_ext, sxy_ext;
  logic [LW-1:0]    sx_abs, sy_abs, sxy_abs, num_abs;
  logic [LW-1:0]    rhs_sh;
  logic             n2_neg;
  logic             fin_early;
  logic [1:0]       early_status;
  logic             load_out;

  corr_acc #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_SAMPLES(MAX_SAMPLES),
    .CNT_W      (CNT_W),
    .SW         (SW),
    .QW         (QW)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .clear     (acc_clear),
    .start     (acc_start),
    .x         (x_sample),
    .y         (y_sample),
    .done      (acc_done),
    .count     (count),
    .overflowed(overflowed),
    .sx        (sx),
    .sy        (sy),
    .sxx       (sxx),
    .syy       (syy),
    .sxy       (sxy)
  );

  corr_mul #(
    .LW(LW),
    .MB(PW)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .product(p)
  );

  assign n_ext   = {{(LW - CNT_W){1'b0}}, count};
  assign sx_ext  = {{(LW - SW){sx[SW-1]}}, sx};
  assign sy_ext  = {{(LW - SW){sy[SW-1]}}, sy};
  assign sxx_ext = {{(LW - QW){sxx[QW-1]}}, sxx};
  assign syy_ext = {{(LW - QW){syy[QW-1]}}, syy};
  assign sxy_ext = {{(LW - QW){sxy[QW-1]}}, sxy};
  assign sx_abs  = sx[SW-1] ? (~sx_ext + 1'b1) : sx_ext;
  assign sy_abs  = sy[SW-1] ? (~sy_ext + 1'b1) : sy_ext;
  assign sxy_abs = sxy[QW-1] ? (~sxy_ext + 1'b1) : sxy_ext;
  assign num_abs = num[LW-1] ? (~num + 1'b1) : num;
  assign n2_neg  = sx[SW-1] ^ sy[SW-1];
  assign rhs_sh  = rhs << corr_pkg::FRAC_SHIFT;
  assign cand    = q | (QB'(1) << bitn);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (op)
      corr_pkg::OP_VX1:  begin mul_a = n_ext;  mul_b = sxx_ext[PW-1:0]; end
      corr_pkg::OP_VX2:  begin mul_a = sx_abs; mul_b = sx_abs[PW-1:0]; end
      corr_pkg::OP_VY1:  begin mul_a = n_ext;  mul_b = syy_ext[PW-1:0]; end
      corr_pkg::OP_VY2:  begin mul_a = sy_abs; mul_b = sy_abs[PW-1:0]; end
      corr_pkg::OP_N1:   begin mul_a = n_ext;  mul_b = sxy_abs[PW-1:0]; end
      corr_pkg::OP_N2:   begin mul_a = sx_abs; mul_b = sy_abs[PW-1:0]; end
      corr_pkg::OP_RHS:  begin mul_a = num_abs; mul_b = num_abs[PW-1:0]; end
      corr_pkg::OP_PROD: begin mul_a = vx;     mul_b = vy[PW-1:0]; end
      corr_pkg::OP_C2: begin
        mul_a = {{(LW - QB){1'b0}}, cand};
        mul_b = {{(PW - QB){1'b0}}, cand};
      end
      corr_pkg::OP_LHS:  begin mul_a = prod;   mul_b = c2[PW-1:0]; end
      default:           begin mul_a = n_ext;  mul_b = '0; end
    endcase
  end

  assign fin_early    = overflowed || (count < CNT_W'(2));
  assign early_status = overflowed ? corr_pkg::STATUS_OVF : corr_pkg::STATUS_UNDEF;

  always_comb begin
    state_next = state;
    op_next    = op;
    in_ready   = 1'b0;
    acc_start  = 1'b0;
    acc_clear  = 1'b0;
    mul_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      corr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          acc_start  = 1'b1;
          state_next = corr_pkg::ST_ACC;
        end
      end
      corr_pkg::ST_ACC: begin
        if (acc_done) begin
          state_next = last_r ? corr_pkg::ST_CHECK : corr_pkg::ST_IDLE;
        end
      end
      corr_pkg::ST_CHECK: begin
        op_next    = corr_pkg::OP_VX1;
        state_next = fin_early ? corr_pkg::ST_OUT : corr_pkg::ST_MUL_GO;
      end
      corr_pkg::ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = corr_pkg::ST_MUL_WAIT;
      end
      corr_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = corr_pkg::ST_MUL_GO;
          case (op)
            corr_pkg::OP_VX1:  op_next = corr_pkg::OP_VX2;
            corr_pkg::OP_VX2:  op_next = corr_pkg::OP_VY1;
            corr_pkg::OP_VY1:  op_next = corr_pkg::OP_VY2;
            corr_pkg::OP_VY2:  op_next = corr_pkg::OP_N1;
            corr_pkg::OP_N1:   op_next = corr_pkg::OP_N2;
            corr_pkg::OP_N2: begin
              op_next = corr_pkg::OP_RHS;
              if (vx == '0 || vy == '0) begin
                state_next = corr_pkg::ST_OUT;
              end
            end
            corr_pkg::OP_RHS:  op_next = corr_pkg::OP_PROD;
            corr_pkg::OP_PROD: op_next = corr_pkg::OP_C2;
            corr_pkg::OP_C2:   op_next = corr_pkg::OP_LHS;
            default: begin
              op_next = corr_pkg::OP_C2;
              if (bitn == '0) begin
                state_next = corr_pkg::ST_OUT;
              end
            end
          endcase
        end
      end
      corr_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          acc_clear  = 1'b1;
          state_next = corr_pkg::ST_IDLE;
        end
      end
      default: state_next = corr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= corr_pkg::ST_IDLE;
      op    <= corr_pkg::OP_VX1;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // Finish datapath. The outcome code is set during the finish and copied out as the result is loaded.
  logic [1:0] fin_status;

  always_ff @(posedge clk) begin
    if (state == corr_pkg::ST_IDLE && in_valid) begin
      last_r <= last_sample;
    end
    if (state == corr_pkg::ST_CHECK) begin
      q          <= '0;
      bitn       <= BW'(QB - 1);
      fin_status <= early_status;
    end
    if (state == corr_pkg::ST_MUL_WAIT && mul_done) begin
      case (op)
        corr_pkg::OP_VX1:  vx <= p;
        corr_pkg::OP_VX2:  vx <= vx - p;
        corr_pkg::OP_VY1:  vy <= p;
        corr_pkg::OP_VY2:  vy <= vy - p;
        corr_pkg::OP_N1:   num <= sxy[QW-1] ? (~p + 1'b1) : p;
        corr_pkg::OP_N2: begin
          num        <= n2_neg ? (num + p) : (num - p);
          fin_status <= corr_pkg::STATUS_UNDEF;
        end
        corr_pkg::OP_RHS: begin
          rhs        <= p;
          fin_status <= corr_pkg::STATUS_OK;
        end
        corr_pkg::OP_PROD: prod <= p;
        corr_pkg::OP_C2:   c2 <= p;
        default: begin
          if (p <= rhs_sh) begin
            q <= cand;
          end
          bitn <= bitn - 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
      status    <= fin_status;
      if (fin_status == corr_pkg::STATUS_OK) begin
        correlation <= num[LW-1] ? (~{1'b0, q} + 1'b1) : {1'b0, q};
      end else begin
        correlation <= '0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == corr_pkg::ST_MUL_WAIT)
    else $error("multiplier finished outside a wait step");

  a_acc_done_waited: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> state == corr_pkg::ST_ACC)
    else $error("pair accumulation finished outside the accumulate step");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != corr_pkg::STATUS_OK |-> correlation == '0)
    else $error("nonzero coefficient with a failing status");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == corr_pkg::STATUS_OK |->
      ($signed(correlation) <= 16'sd16384 && $signed(correlation) >= -16'sd16384))
    else $error("coefficient out of the Q1.14 range");

  a_clear_on_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> count == '0 && !overflowed)
    else $error("sums not cleared after a result");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;

  typedef logic signed [255:0] acc_t;

  class corr_scoreboard;
    logic [31:0] pair_total;
    acc_t sx, sy, sxx, syy, sxy;
    bit saw_overflow;
    logic [15:0] coef_q[$];
    logic [1:0] status_q[$];
    int errors;
    int results_seen;
    int status_hits[3];

    function new();
      errors = 0;
      results_seen = 0;
      clear_series();
    endfunction

    function void clear_series();
      pair_total = 0;
      sx = 0;
      sy = 0;
      sxx = 0;
      syy = 0;
      sxy = 0;
      saw_overflow = 0;
    endfunction

    // Exact Pearson coefficient of the series so far, as Q1.14 plus status.
    function void coefficient_of_series(output logic [15:0] coef, output logic [1:0] st);
      acc_t n, vx, vy, num, mag, rhs, prod, cand, q;
      coef = 0;
      if (saw_overflow) begin
        st = corr_pkg::STATUS_OVF;
        return;
      end
      if (pair_total < 2) begin
        st = corr_pkg::STATUS_UNDEF;
        return;
      end
      n = pair_total;
      vx = n * sxx - sx * sx;
      vy = n * syy - sy * sy;
      if (vx == 0 || vy == 0) begin
        st = corr_pkg::STATUS_UNDEF;
        return;
      end
      num = n * sxy - sx * sy;
      mag = (num < 0) ? -num : num;
      rhs = (mag * mag) <<< corr_pkg::FRAC_SHIFT;
      prod = vx * vy;
      q = 0;
      for (int b = corr_pkg::Q_BITS - 1; b >= 0; b--) begin
        cand = q | (acc_t'(1) <<< b);
        if (cand * cand * prod <= rhs) q = cand;
      end
      coef = (num < 0) ? 16'(-q) : 16'(q);
      st = corr_pkg::STATUS_OK;
    endfunction

    function void note_request(logic [15:0] x, logic [15:0] y, logic last);
      acc_t xv, yv;
      logic [15:0] c;
      logic [1:0] s;
      xv = acc_t'($signed(x));
      yv = acc_t'($signed(y));
      if (pair_total < 65536) begin
        sx = sx + xv;
        sy = sy + yv;
        sxx = sxx + xv * xv;
        syy = syy + yv * yv;
        sxy = sxy + xv * yv;
        pair_total++;
      end else begin
        saw_overflow = 1;
      end
      if (last) begin
        coefficient_of_series(c, s);
        coef_q.push_back(c);
        status_q.push_back(s);
        clear_series();
      end
    endfunction

    function void check_result(logic [15:0] c, logic [1:0] s);
      logic [15:0] ec;
      logic [1:0] es;
      if (coef_q.size() == 0) begin
        $display("%0t: unexpected result correlation=%0d status=%0d",
                 $time, $signed(c), s);
        errors++;
        return;
      end
      ec = coef_q.pop_front();
      es = status_q.pop_front();
      results_seen++;
      if (es <= corr_pkg::STATUS_OVF) status_hits[es]++;
      if (c !== ec) begin
        $display("%0t: correlation expected %0d actual %0d", $time, $signed(ec), $signed(c));
        errors++;
      end
      if (s !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, s);
        errors++;
      end
    endfunction

    function int pending();
      return coef_q.size();
    endfunction
  endclass

  // Kinds of generated series.
  localparam int SERIES_INDEP   = 0;
  localparam int SERIES_CORR    = 1;
  localparam int SERIES_ANTI    = 2;
  localparam int SERIES_CONST_X = 3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [15:0] x_sample;
  logic [15:0] y_sample;
  logic last_sample;
  logic out_valid;
  logic out_ready;
  logic [15:0] correlation;
  logic [1:0] status;

  corr_scoreboard sb;
  bit quiet;
  int items_sent;
  int cycle_count;

  streaming_correlation_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .x_sample(x_sample),
    .y_sample(y_sample),
    .last_sample(last_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .correlation(correlation),
    .status(status)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 8000000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(correlation, status);
  end

  // Result side back-pressure in bursts.
  initial begin
    int hold;
    hold = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 17);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic send_pair(logic [15:0] x, logic [15:0] y, logic last);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    x_sample <= x;
    y_sample <= y;
    last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(x, y, last);
    items_sent++;
  endtask

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'(32767);
    if (v < -32768) return 16'(-32768);
    return 16'(v);
  endfunction

  task automatic send_series(int len, int kind);
    int xv, yv, noise;
    logic [15:0] xc;
    xc = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      xv = $signed(16'($urandom));
      noise = $urandom_range(0, 1) ? $signed(16'($urandom)) >>> $urandom_range(0, 15) : 0;
      case (kind)
        SERIES_CORR: yv = xv + noise;
        SERIES_ANTI: yv = -xv + noise;
        default: yv = $signed(16'($urandom));
      endcase
      send_pair(kind == SERIES_CONST_X ? xc : 16'(xv), clip16(yv), i == len - 1);
    end
  endtask

  initial begin
    sb = new();
    quiet = 0;
    items_sent = 0;
    rst = 1;
    in_valid = 0;
    x_sample = 0;
    y_sample = 0;
    last_sample = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // A single pair, and a constant y, are undefined.
    send_pair(16'h7fff, 16'h8000, 1);
    send_pair(16'h1234, 16'h0005, 0);
    send_pair(16'h8000, 16'h0005, 1);
    // Perfect correlation and anticorrelation at the extremes, then a nearly anticorrelated series.
    send_pair(16'h8000, 16'h8000, 0);
    send_pair(16'h7fff, 16'h7fff, 1);
    send_pair(16'h8000, 16'h7fff, 0);
    send_pair(16'h7fff, 16'h8000, 0);
    send_pair(16'h0000, 16'hffff, 1);
    send_pair(16'hffff, 16'h0000, 0);
    send_pair(16'h0001, 16'hffff, 0);
    send_pair(16'h5555, 16'haaaa, 1);
    send_series(5, SERIES_CONST_X);
    send_series(4, SERIES_CORR);

    while (items_sent < 400) begin
      if (items_sent > 320) quiet = 1;
      case ($urandom_range(0, 9))
        0: send_series(1, SERIES_INDEP);
        1: send_series($urandom_range(2, 6), SERIES_CONST_X);
        2, 3: send_series($urandom_range(2, 12), SERIES_CORR);
        4: send_series($urandom_range(2, 12), SERIES_ANTI);
        default: send_series($urandom_range(2, 10), SERIES_INDEP);
      endcase
    end
    in_valid <= 0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d pairs; %0d coefficients checked (ok %0d, undefined %0d, overflow %0d).",
             items_sent, sb.results_seen, sb.status_hits[corr_pkg::STATUS_OK],
             sb.status_hits[corr_pkg::STATUS_UNDEF], sb.status_hits[corr_pkg::STATUS_OVF]);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
